>>> rtl/etf_pkg.sv
package etf_pkg;

  localparam int unsigned ImageWidth  = 1024;
  localparam int unsigned ImageHeight = 1024;
  localparam int unsigned CountBits   = 10;
  localparam int unsigned FracBits    = 28;

  localparam logic [63:0] EscapeQ56 = 64'h0400_0000_0000_0000;
  localparam logic [31:0] Black     = 32'h0000_0000;

  localparam logic signed [31:0] RstMinRe     = -32'sd536870912;
  localparam logic signed [31:0] RstMaxRe     = 32'sd536870912;
  localparam logic signed [31:0] RstMinIm     = -32'sd536870912;
  localparam logic signed [31:0] RstMaxIm     = 32'sd536870912;
  localparam logic        [9:0]  RstIterLimit = 10'd100;
  localparam logic        [23:0] RstColour    = 24'd1;

  localparam logic signed [47:0] SatMax = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SatMin = -48'sh0000_8000_0000;

  typedef enum logic [2:0] {
    CFG_MIN_RE,
    CFG_MAX_RE,
    CFG_MIN_IM,
    CFG_MAX_IM,
    CFG_SET_MODE,
    CFG_ITER_LIMIT,
    CFG_COLOUR_BASE,
    CFG_JULIA_C
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_MAP_END,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_COL_SQ,
    ST_COL_MUL,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [9:0] pixel_col;
    logic [9:0] pixel_row;
  } pixel_in_t;

  typedef struct packed {
    logic [9:0]  out_col;
    logic [9:0]  out_row;
    logic [9:0]  iteration_count;
    logic        bounded;
    logic [31:0] pixel_colour;
  } pixel_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SatMax) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SatMin) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/escape_time_fractal_pixel_core.sv
// Escape-time fractal pixel core (Mandelbrot or Julia, Q4.28 fixed point). Each accepted
// item is a pixel position; it is mapped into the configured complex window and iterated
// until |z|^2 exceeds 4 or the count reaches iteration_limit. One signed 33x33 multiplier
// does all the multiplications: two products for the window mapping, three per iteration
// (zr*zr, zi*zi, zr*zi) and two for the colour.
// The input stalls from acceptance until the result moves into the output register; a
// result waiting there holds only the final hand-over, not the iteration.
module escape_time_fractal_pixel_core #(
  parameter int unsigned IMAGE_WIDTH  = etf_pkg::ImageWidth,
  parameter int unsigned IMAGE_HEIGHT = etf_pkg::ImageHeight,
  parameter int unsigned COUNT_BITS   = etf_pkg::CountBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  etf_pkg::pixel_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output etf_pkg::pixel_out_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  localparam int unsigned ColShift = $clog2(IMAGE_WIDTH);
  localparam int unsigned RowShift = $clog2(IMAGE_HEIGHT);

  logic signed [31:0] min_re_q, max_re_q, min_im_q, max_im_q;
  logic               julia_q;
  logic [9:0]         limit_q;
  logic [23:0]        colour_base_q;
  logic [63:0]        julia_c_q;

  etf_pkg::state_e state_q, state_d;

  logic [9:0]              col_q, row_q;
  logic signed [31:0]      pr_q, pi_q, zr_q, zi_q;
  logic [62:0]             rr_q;
  logic signed [65:0]      prod_q;
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic                    bounded_q, bounded_d;
  logic                    first_q;
  logic                    out_valid_q;
  etf_pkg::pixel_out_t     out_q;

  logic signed [32:0]      op_a, op_b;
  logic signed [65:0]      prod;
  logic signed [32:0]      span_re, span_im;
  logic signed [31:0]      map_re, map_im;
  logic signed [31:0]      cr;
  logic signed [32:0]      ci;
  logic signed [63:0]      diff;
  logic [63:0]             mag;
  logic                    escape;
  logic signed [31:0]      new_zr, new_zi;
  logic [COUNT_BITS-1:0]   limit;
  logic [COUNT_BITS-1:0]   count_inc;
  logic                    load_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_re_q      <= etf_pkg::RstMinRe;
      max_re_q      <= etf_pkg::RstMaxRe;
      min_im_q      <= etf_pkg::RstMinIm;
      max_im_q      <= etf_pkg::RstMaxIm;
      julia_q       <= 1'b0;
      limit_q       <= etf_pkg::RstIterLimit;
      colour_base_q <= etf_pkg::RstColour;
      julia_c_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (etf_pkg::cfg_idx_e'(cfg_index_i))
        etf_pkg::CFG_MIN_RE:      min_re_q      <= cfg_data_i[31:0];
        etf_pkg::CFG_MAX_RE:      max_re_q      <= cfg_data_i[31:0];
        etf_pkg::CFG_MIN_IM:      min_im_q      <= cfg_data_i[31:0];
        etf_pkg::CFG_MAX_IM:      max_im_q      <= cfg_data_i[31:0];
        etf_pkg::CFG_SET_MODE:    julia_q       <= cfg_data_i[0];
        etf_pkg::CFG_ITER_LIMIT:  limit_q       <= cfg_data_i[9:0];
        etf_pkg::CFG_COLOUR_BASE: colour_base_q <= cfg_data_i[23:0];
        etf_pkg::CFG_JULIA_C:     julia_c_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign limit   = COUNT_BITS'(limit_q);
  assign span_re = 33'(max_re_q) - 33'(min_re_q);
  assign span_im = 33'(max_im_q) - 33'(min_im_q);
  assign map_re  = etf_pkg::sat32(48'(prod_q >>> ColShift) + 48'(min_re_q));
  assign map_im  = etf_pkg::sat32(48'(prod_q >>> RowShift) + 48'(min_im_q));

  assign cr = julia_q ? $signed(julia_c_q[63:32]) : pr_q;
  assign ci = julia_q ? 33'sd0 - 33'($signed(julia_c_q[31:0])) : 33'(pi_q);

  assign diff   = $signed({1'b0, rr_q}) - $signed({1'b0, prod_q[62:0]});
  assign mag    = {1'b0, rr_q} + {1'b0, prod_q[62:0]};
  assign escape = mag > etf_pkg::EscapeQ56;
  assign new_zr = etf_pkg::sat32(48'(diff >>> etf_pkg::FracBits) + 48'(cr));
  assign new_zi = etf_pkg::sat32(48'(prod_q >>> (etf_pkg::FracBits - 1)) + 48'(ci));
  assign count_inc = count_q + COUNT_BITS'(1);

  always_comb begin
    case (state_q)
      etf_pkg::ST_MAP_RE: begin
        op_a = 33'(col_q);
        op_b = span_re;
      end
      etf_pkg::ST_MAP_IM: begin
        op_a = 33'(row_q);
        op_b = span_im;
      end
      etf_pkg::ST_SQ_RE: begin
        op_a = 33'(zr_q);
        op_b = 33'(zr_q);
      end
      etf_pkg::ST_SQ_IM: begin
        op_a = 33'(zi_q);
        op_b = 33'(zi_q);
      end
      etf_pkg::ST_CROSS: begin
        op_a = 33'(zr_q);
        op_b = 33'(zi_q);
      end
      etf_pkg::ST_COL_SQ: begin
        op_a = 33'(count_q);
        op_b = 33'(count_q);
      end
      etf_pkg::ST_COL_MUL: begin
        op_a = 33'(colour_base_q);
        op_b = {1'b0, prod_q[31:0]};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    bounded_d  = bounded_q;
    load_out   = 1'b0;
    in_stall_o = (state_q != etf_pkg::ST_IDLE);
    case (state_q)
      etf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d   = etf_pkg::ST_MAP_RE;
          count_d   = '0;
          bounded_d = 1'b0;
        end
      end
      etf_pkg::ST_MAP_RE:  state_d = etf_pkg::ST_MAP_IM;
      etf_pkg::ST_MAP_IM:  state_d = etf_pkg::ST_MAP_END;
      etf_pkg::ST_MAP_END: begin
        state_d   = etf_pkg::ST_SQ_RE;
        count_d   = '0;
        bounded_d = 1'b0;
      end
      etf_pkg::ST_SQ_RE:   state_d = etf_pkg::ST_SQ_IM;
      etf_pkg::ST_SQ_IM:   state_d = etf_pkg::ST_CROSS;
      etf_pkg::ST_CROSS: begin
        if (first_q) begin
          if (limit == '0) begin
            bounded_d = 1'b1;
            state_d   = etf_pkg::ST_RESULT;
          end else begin
            state_d = etf_pkg::ST_SQ_RE;
          end
        end else if (escape) begin
          state_d = etf_pkg::ST_COL_SQ;
        end else begin
          count_d = count_inc;
          if (count_inc == limit) begin
            bounded_d = 1'b1;
            state_d   = etf_pkg::ST_RESULT;
          end else begin
            state_d = etf_pkg::ST_SQ_RE;
          end
        end
      end
      etf_pkg::ST_COL_SQ:  state_d = etf_pkg::ST_COL_MUL;
      etf_pkg::ST_COL_MUL: state_d = etf_pkg::ST_RESULT;
      etf_pkg::ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = etf_pkg::ST_IDLE;
        end
      end
      default: state_d = etf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= etf_pkg::ST_IDLE;
      count_q     <= '0;
      bounded_q   <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      bounded_q <= bounded_d;
      if (state_q == etf_pkg::ST_MAP_END) begin
        first_q <= 1'b1;
      end else if (state_q == etf_pkg::ST_CROSS) begin
        first_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q != etf_pkg::ST_RESULT) begin
      prod_q <= prod;
    end
    case (state_q)
      etf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          col_q <= in_item_i.pixel_col;
          row_q <= in_item_i.pixel_row;
        end
      end
      etf_pkg::ST_MAP_IM: pr_q <= map_re;
      etf_pkg::ST_MAP_END: begin
        pi_q <= map_im;
        zr_q <= julia_q ? pr_q : '0;
        zi_q <= julia_q ? map_im : '0;
      end
      etf_pkg::ST_SQ_RE: begin
        if (!first_q) begin
          zi_q <= new_zi;
        end
      end
      etf_pkg::ST_SQ_IM: rr_q <= prod_q[62:0];
      etf_pkg::ST_CROSS: zr_q <= new_zr;
      etf_pkg::ST_RESULT: begin
        if (load_out) begin
          out_q.out_col         <= col_q;
          out_q.out_row         <= row_q;
          out_q.iteration_count <= 10'(count_q);
          out_q.bounded         <= bounded_q;
          out_q.pixel_colour    <= bounded_q ? etf_pkg::Black : prod_q[31:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_bounded_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.bounded |-> out_item_o.pixel_colour == etf_pkg::Black)
    else $error("bounded item with nonzero colour");

  a_bounded_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.bounded |-> out_item_o.iteration_count == 10'(limit))
    else $error("bounded item count differs from limit");

  a_escaped_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.bounded |-> out_item_o.iteration_count < 10'(limit))
    else $error("escaped item count not below limit");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != etf_pkg::ST_IDLE |-> count_q <= limit)
    else $error("iteration count beyond limit");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == etf_pkg::ST_MAP_RE)
    else $error("accepted item did not start mapping");

endmodule

>>> verif/escape_time_fractal_pixel_checker.sv
`timescale 1ns / 1ps
module escape_time_fractal_pixel_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  etf_pkg::pixel_in_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  etf_pkg::pixel_out_t out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);
  import etf_pkg::*;

  localparam int     ColShift = $clog2(ImageWidth);
  localparam int     RowShift = $clog2(ImageHeight);
  localparam longint QMax     = 64'sd2147483647;
  localparam longint QMin     = -64'sd2147483648;

  logic signed [31:0] min_re, max_re, min_im, max_im;
  logic               julia_mode;
  logic [9:0]         iter_limit;
  logic [23:0]        colour_base;
  logic [63:0]        julia_c;
  pixel_out_t         pixel_results_q[$];
  pixel_out_t         want;

  function automatic longint clamp_q428(input longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  function automatic longint map_axis(input logic [9:0] idx, input logic signed [31:0] lo,
                                      input logic signed [31:0] hi, input int shift);
    longint span_w;
    longint offset;
    span_w = longint'(hi) - longint'(lo);
    offset = (longint'(idx) * span_w) >>> shift;
    return clamp_q428(longint'(lo) + offset);
  endfunction

  function automatic pixel_out_t render_pixel(input pixel_in_t px);
    pixel_out_t  res;
    longint      pt_re, pt_im, zr, zi, cr, ci, rr, ii, ri;
    logic [63:0] mag;
    logic [63:0] shade;
    int unsigned count;
    int unsigned lim;
    pt_re = map_axis(px.pixel_col, min_re, max_re, ColShift);
    pt_im = map_axis(px.pixel_row, min_im, max_im, RowShift);
    lim   = int'(iter_limit);
    count = 0;
    if (julia_mode) begin
      zr = pt_re;
      zi = pt_im;
      cr = longint'($signed(julia_c[63:32]));
      ci = -longint'($signed(julia_c[31:0]));
    end else begin
      zr = 0;
      zi = 0;
      cr = pt_re;
      ci = pt_im;
    end
    while (count < lim) begin
      rr  = zr * zr;
      ii  = zi * zi;
      ri  = zr * zi;
      zr  = clamp_q428(((rr - ii) >>> FracBits) + cr);
      zi  = clamp_q428((ri >>> (FracBits - 1)) + ci);
      mag = $unsigned(zr * zr) + $unsigned(zi * zi);
      if (mag > EscapeQ56) break;
      count++;
    end
    shade               = 64'(colour_base) * 64'(count) * 64'(count);
    res.out_col         = px.pixel_col;
    res.out_row         = px.pixel_row;
    res.iteration_count = 10'(count);
    res.bounded         = (count == lim);
    res.pixel_colour    = res.bounded ? Black : shade[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_re      = RstMinRe;
      max_re      = RstMaxRe;
      min_im      = RstMinIm;
      max_im      = RstMaxIm;
      julia_mode  = 1'b0;
      iter_limit  = RstIterLimit;
      colour_base = RstColour;
      julia_c     = '0;
      pixel_results_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_RE:      min_re = cfg_data_i[31:0];
          CFG_MAX_RE:      max_re = cfg_data_i[31:0];
          CFG_MIN_IM:      min_im = cfg_data_i[31:0];
          CFG_MAX_IM:      max_im = cfg_data_i[31:0];
          CFG_SET_MODE:    julia_mode = cfg_data_i[0];
          CFG_ITER_LIMIT:  iter_limit = cfg_data_i[9:0];
          CFG_COLOUR_BASE: colour_base = cfg_data_i[23:0];
          CFG_JULIA_C:     julia_c = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pixel_results_q.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("unexpected result (%0d,%0d) count %0d bounded %0b colour %h",
                     out_item_i.out_col, out_item_i.out_row, out_item_i.iteration_count,
                     out_item_i.bounded, out_item_i.pixel_colour);
          end
          mismatch_count_o++;
        end else begin
          want = pixel_results_q.pop_front();
          if (out_item_i.out_col !== want.out_col || out_item_i.out_row !== want.out_row ||
              out_item_i.iteration_count !== want.iteration_count ||
              out_item_i.bounded !== want.bounded ||
              out_item_i.pixel_colour !== want.pixel_colour) begin
            if (mismatch_count_o < 10) begin
              $display("pixel (%0d,%0d): expected count %0d bounded %0b colour %h",
                       want.out_col, want.out_row, want.iteration_count, want.bounded,
                       want.pixel_colour);
              $display("  got (%0d,%0d) count %0d bounded %0b colour %h",
                       out_item_i.out_col, out_item_i.out_row, out_item_i.iteration_count,
                       out_item_i.bounded, out_item_i.pixel_colour);
            end
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pixel_results_q.push_back(render_pixel(in_item_i));
      end
      pending_o = pixel_results_q.size();
    end
  end

endmodule

>>> verif/escape_time_fractal_pixel_core_test.sv
`timescale 1ns / 1ps
module escape_time_fractal_pixel_core_test;
  import etf_pkg::*;

  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 40;
  localparam int RandomPhases = 16;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pixel_in_t   in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pixel_out_t  out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;
  int          mismatches;
  int          pending;
  bit          hold_req  = 1'b0;
  bit          quiet_in  = 1'b0;
  bit          quiet_out = 1'b0;
  int          sent      = 0;
  int          taken     = 0;

  always #5 clk = ~clk;

  escape_time_fractal_pixel_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  escape_time_fractal_pixel_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  task automatic set_reg(input cfg_idx_e idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
  endtask

  task automatic close_cfg();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(input logic [31:0] lo_re, input logic [31:0] hi_re,
                            input logic [31:0] lo_im, input logic [31:0] hi_im);
    set_reg(CFG_MIN_RE, {32'($urandom), lo_re});
    set_reg(CFG_MAX_RE, {32'($urandom), hi_re});
    set_reg(CFG_MIN_IM, {32'($urandom), lo_im});
    set_reg(CFG_MAX_IM, {32'($urandom), hi_im});
  endtask

  task automatic pick_axis(output logic [31:0] lo, output logic [31:0] hi);
    int          centre;
    int          half;
    int unsigned sel;
    sel    = $urandom_range(0, 7);
    centre = int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
    half   = int'($urandom_range(32'h0001_0000, 32'h2000_0000));
    if (sel == 0) begin
      lo = $urandom;
      hi = $urandom;
    end else if (sel == 1) begin
      lo = centre + half;
      hi = centre - half;
    end else begin
      lo = centre - half;
      hi = centre + half;
    end
  endtask

  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
    pixel_in_t px;
    int        gap;
    if (sent % 20 == 0) quiet_in = ($urandom_range(0, 3) == 0);
    gap = quiet_in ? 0 : int'($urandom_range(0, 13));
    px.pixel_col = col;
    px.pixel_row = row;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= px;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (taken % 20 == 0) quiet_out = ($urandom_range(0, 3) == 0);
      gap = quiet_out ? 0 : int'($urandom_range(0, 13));
      if (hold_req) begin
        gap      = HoldCycles;
        hold_req = 1'b0;
      end
      if (gap != 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      taken++;
    end
  end

  initial begin
    #10_000_000;
    $display("escape_time_fractal_pixel_core: mismatch");
    $finish;
  end

  initial begin
    logic [31:0] lo_re, hi_re, lo_im, hi_im;
    logic [9:0]  lim;
    logic [23:0] colour;
    logic [63:0] junk;
    logic [63:0] jc;
    int          count;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd256, 10'd768);

    settle();
    set_reg(CFG_ITER_LIMIT, 64'd0);
    set_reg(CFG_COLOUR_BASE, 64'hFF_FFFF);
    close_cfg();
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd3, 10'd1000);

    settle();
    set_reg(CFG_ITER_LIMIT, 64'd1);
    close_cfg();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd512, 10'd512);

    settle();
    set_reg(CFG_ITER_LIMIT, 64'd1023);
    close_cfg();
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd300, 10'd600);

    // widest span, imaginary axis reversed
    settle();
    set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    set_reg(CFG_ITER_LIMIT, 64'd20);
    close_cfg();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd1023, 10'd0);

    settle();
    set_window(RstMinRe, RstMaxRe, RstMinIm, RstMaxIm);
    set_reg(CFG_SET_MODE, 64'd1);
    set_reg(CFG_JULIA_C, 64'hF333_3333_027E_F9DB);
    set_reg(CFG_ITER_LIMIT, 64'd60);
    set_reg(CFG_COLOUR_BASE, 64'h00_0101);
    close_cfg();
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd600, 10'd400);
    send_pixel(10'd400, 10'd600);

    settle();
    set_reg(CFG_JULIA_C, 64'h8000_0000_8000_0000);
    set_reg(CFG_ITER_LIMIT, 64'd10);
    set_reg(CFG_COLOUR_BASE, 64'd0);
    close_cfg();
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd100, 10'd900);

    for (int k = 0; k < RandomPhases; k++) begin
      case (k % 8)
        3: begin
          lim   = 10'($urandom_range(49, 255));
          count = 15;
        end
        7: begin
          lim   = 10'($urandom_range(256, 1023));
          count = 4;
        end
        default: begin
          lim   = ($urandom_range(0, 15) == 0) ? 10'd0 : 10'($urandom_range(1, 48));
          count = 45;
        end
      endcase
      colour = ($urandom_range(0, 7) == 0) ? 24'hFF_FFFF : 24'($urandom);
      if ($urandom_range(0, 5) == 0) begin
        jc = {32'($urandom), 32'($urandom)};
      end else begin
        jc[63:32] = 32'(int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        jc[31:0]  = 32'(int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
      end
      pick_axis(lo_re, hi_re);
      pick_axis(lo_im, hi_im);
      junk = {32'($urandom), 32'($urandom)};

      settle();
      set_window(lo_re, hi_re, lo_im, hi_im);
      set_reg(CFG_SET_MODE, {junk[63:1], 1'($urandom_range(0, 1))});
      set_reg(CFG_ITER_LIMIT, {junk[63:10], lim});
      set_reg(CFG_COLOUR_BASE, {junk[63:24], colour});
      set_reg(CFG_JULIA_C, jc);
      close_cfg();
      if (k == 5) hold_req = 1'b1;
      repeat (count) send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("escape_time_fractal_pixel_core: match");
    end else begin
      $display("escape_time_fractal_pixel_core: mismatch");
    end
    $finish;
  end

endmodule
